/* sv/cgdr_pkg.sv */
// ----------------------------------------------------------------------------
// cgdr_pkg
// shared types, constants and the squared color distance function of the
// color guided depth refinement block
// ----------------------------------------------------------------------------
package cgdr_pkg;

   localparam int CHAN_W     = 8;
   localparam int SQ_W       = 2 * CHAN_W;
   localparam int DEPTH_W    = 8;
   localparam int THR_W      = 9;
   localparam int THR_SQ_W   = 2 * THR_W;
   localparam int DIST_W     = 18;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;

   localparam logic [THR_W-1:0]    THR_RESET    = 9'd5;
   localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = THR_SQ_W'(THR_RESET) * THR_SQ_W'(THR_RESET);

   // result queue, one entry holds the one or two results of an item
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = FIFO_AW + 1;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgb_type;

   // item in the distance stage
   typedef struct packed {
      rgb_type            left_rgb;
      rgb_type            held_rgb;
      rgb_type            new_rgb;
      logic [DEPTH_W-1:0] held_depth;
      logic [DEPTH_W-1:0] new_depth;
      logic               held_valid;
      logic               held_first;
      logic               row_end;
   } dist_job_type;

   // item in the select stage
   typedef struct packed {
      logic [DEPTH_W-1:0] held_depth;
      logic [DEPTH_W-1:0] new_depth;
      logic               take_left;
      logic               take_right;
      logic               held_valid;
      logic               row_end;
   } sel_job_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth0;
      logic               row_last0;
      logic               run_last0;
      logic [DEPTH_W-1:0] depth1;
      logic               two;
   } rsp_entry_type;

   function automatic logic [DIST_W-1:0] dist2(input rgb_type a, input rgb_type b);
      logic [CHAN_W-1:0] dr;
      logic [CHAN_W-1:0] dg;
      logic [CHAN_W-1:0] db;
      logic [SQ_W-1:0]   sr;
      logic [SQ_W-1:0]   sg;
      logic [SQ_W-1:0]   sb;
      dr = (a.red   > b.red)   ? a.red   - b.red   : b.red   - a.red;
      dg = (a.green > b.green) ? a.green - b.green : b.green - a.green;
      db = (a.blue  > b.blue)  ? a.blue  - b.blue  : b.blue  - a.blue;
      sr = SQ_W'(dr) * SQ_W'(dr);
      sg = SQ_W'(dg) * SQ_W'(dg);
      sb = SQ_W'(db) * SQ_W'(db);
      return {2'b00, sr} + {2'b00, sg} + {2'b00, sb};
   endfunction

endpackage

/* sv/color_guided_depth_refine.sv */
// ----------------------------------------------------------------------------
// color_guided_depth_refine
// sharpens depth edges along each row of a pixel stream, guided by the
// color difference between the left and right neighbors of each pixel
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | contents
//  req      | in  | req_tvalid/tready    | pixel color, raw depth, row end
//  rsp      | out | rsp_tvalid/tready    | refined depth, row last, run last
//  csr      | in  | csr_we               | edge threshold
//
//  one pixel per cycle while req_tready holds, each pixel causes zero to two results
//  a result is offered once it has passed the distance stage, the select stage
//  and the queue output register
//  the result queue holds eight entries behind its output register;
//  req_tready drops once the results in flight could overrun it, so a stall
//  on rsp reaches req with no loss
//  reset is synchronous, clears the pipeline and the queue, and reloads the default threshold
// ----------------------------------------------------------------------------
module color_guided_depth_refine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cgdr_pkg::REQ_DATA_W-1:0]   req_tdata,   // red, green, blue, depth_in
   input  logic                              req_tlast,   // row_end
   input  logic                              csr_we,
   input  logic [cgdr_pkg::THR_W-1:0]        csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cgdr_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // depth_out
   output logic                              rsp_tlast,   // row_last
   output logic                              rsp_tuser    // run_last
);

   logic [cgdr_pkg::THR_SQ_W-1:0] thr_sq_ff;
   logic [cgdr_pkg::THR_SQ_W-1:0] thr_sq_in;

   cgdr_pkg::rgb_type             left_rgb_ff;
   cgdr_pkg::rgb_type             held_rgb_ff;
   logic [cgdr_pkg::DEPTH_W-1:0]  held_depth_ff;
   logic                          held_valid_ff;
   logic                          held_first_ff;
   logic [cgdr_pkg::DEPTH_W-1:0]  left_ref_ff;
   logic [cgdr_pkg::DEPTH_W-1:0]  left_ref_in;

   cgdr_pkg::dist_job_type        dist_ff;
   cgdr_pkg::dist_job_type        dist_in;
   logic                          dist_vld_ff;
   cgdr_pkg::sel_job_type         sel_ff;
   cgdr_pkg::sel_job_type         sel_in;
   logic                          sel_vld_ff;

   cgdr_pkg::rsp_entry_type       fifo_mem [cgdr_pkg::FIFO_DEPTH];
   cgdr_pkg::rsp_entry_type       fifo_wdata;
   cgdr_pkg::rsp_entry_type       head_ff;
   logic                          head_vld_ff;
   logic                          head_vld_in;
   logic [cgdr_pkg::FIFO_AW-1:0]  wptr_ff;
   logic [cgdr_pkg::FIFO_AW-1:0]  rptr_ff;
   logic [cgdr_pkg::CNT_W-1:0]    fcnt_ff;
   logic [cgdr_pkg::CNT_W-1:0]    fcnt_in;
   logic                          sub_ff;
   logic                          sub_in;
   logic [cgdr_pkg::CNT_W-1:0]    resv_ff;
   logic [cgdr_pkg::CNT_W-1:0]    resv_in;

   cgdr_pkg::rgb_type             new_rgb;
   logic [cgdr_pkg::DEPTH_W-1:0]  new_depth;
   logic                          req_xfer;
   logic                          rsp_xfer;
   logic [1:0]                    n_res;
   logic                          fifo_wr;
   logic                          fifo_rd;
   logic                          head_load;
   logic                          mem_wr;
   logic                          mem_rd;
   logic [cgdr_pkg::DIST_W-1:0]   d_lr;
   logic [cgdr_pkg::DIST_W-1:0]   d_lh;
   logic [cgdr_pkg::DIST_W-1:0]   d_hr;
   logic                          is_edge;
   logic                          left_near;
   logic [cgdr_pkg::DEPTH_W-1:0]  refined;

   assign new_rgb.red   = req_tdata[7:0];
   assign new_rgb.green = req_tdata[15:8];
   assign new_rgb.blue  = req_tdata[23:16];
   assign new_depth     = req_tdata[31:24];

   assign req_tready = (resv_ff <= cgdr_pkg::CNT_W'(cgdr_pkg::FIFO_DEPTH - 2));
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign n_res      = {1'b0, held_valid_ff} + {1'b0, req_tlast};

   // threshold squared, computed once per write
   always_comb begin
      thr_sq_in = thr_sq_ff;
      if (csr_we) begin
         thr_sq_in = cgdr_pkg::THR_SQ_W'(csr_wdata) * cgdr_pkg::THR_SQ_W'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_sq_ff <= cgdr_pkg::THR_SQ_RESET;
      end else begin
         thr_sq_ff <= thr_sq_in;
      end
   end

   // pending pixel and its left neighbor color
   always_ff @(posedge clock) begin
      if (reset) begin
         left_rgb_ff   <= '0;
         held_rgb_ff   <= '0;
         held_depth_ff <= '0;
         held_valid_ff <= 1'b0;
         held_first_ff <= 1'b1;
      end else if (req_xfer) begin
         if (held_valid_ff) begin
            left_rgb_ff <= held_rgb_ff;
         end
         if (req_tlast) begin
            held_valid_ff <= 1'b0;
            held_first_ff <= 1'b1;
         end else begin
            held_first_ff <= !held_valid_ff;
            held_rgb_ff   <= new_rgb;
            held_depth_ff <= new_depth;
            held_valid_ff <= 1'b1;
         end
      end
   end

   // distance stage
   always_comb begin
      dist_in.left_rgb   = left_rgb_ff;
      dist_in.held_rgb   = held_rgb_ff;
      dist_in.new_rgb    = new_rgb;
      dist_in.held_depth = held_depth_ff;
      dist_in.new_depth  = new_depth;
      dist_in.held_valid = held_valid_ff;
      dist_in.held_first = held_first_ff;
      dist_in.row_end    = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_vld_ff <= 1'b0;
      end else begin
         dist_vld_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         dist_ff <= dist_in;
      end
   end

   always_comb begin
      d_lr      = cgdr_pkg::dist2(dist_ff.left_rgb, dist_ff.new_rgb);
      d_lh      = cgdr_pkg::dist2(dist_ff.left_rgb, dist_ff.held_rgb);
      d_hr      = cgdr_pkg::dist2(dist_ff.held_rgb, dist_ff.new_rgb);
      is_edge   = !dist_ff.held_first && (d_lr > thr_sq_ff);
      left_near = d_lh < d_hr;
      sel_in.held_depth = dist_ff.held_depth;
      sel_in.new_depth  = dist_ff.new_depth;
      sel_in.take_left  = is_edge && left_near;
      sel_in.take_right = is_edge && !left_near;
      sel_in.held_valid = dist_ff.held_valid;
      sel_in.row_end    = dist_ff.row_end;
   end

   // select stage
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_vld_ff <= 1'b0;
      end else begin
         sel_vld_ff <= dist_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (dist_vld_ff) begin
         sel_ff <= sel_in;
      end
   end

   always_comb begin
      if (sel_ff.take_left) begin
         refined = left_ref_ff;
      end else if (sel_ff.take_right) begin
         refined = sel_ff.new_depth;
      end else begin
         refined = sel_ff.held_depth;
      end
      left_ref_in = left_ref_ff;
      if (sel_vld_ff && sel_ff.held_valid) begin
         left_ref_in = refined;
      end
      fifo_wr              = sel_vld_ff && (sel_ff.held_valid || sel_ff.row_end);
      fifo_wdata.depth0    = sel_ff.held_valid ? refined : sel_ff.new_depth;
      fifo_wdata.row_last0 = !sel_ff.held_valid;
      fifo_wdata.run_last0 = !(sel_ff.held_valid && sel_ff.row_end);
      fifo_wdata.depth1    = sel_ff.new_depth;
      fifo_wdata.two       = sel_ff.held_valid && sel_ff.row_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ref_ff <= '0;
      end else begin
         left_ref_ff <= left_ref_in;
      end
   end

   // result queue with registered head
   assign rsp_tvalid = head_vld_ff;
   assign rsp_tdata  = sub_ff ? head_ff.depth1 : head_ff.depth0;
   assign rsp_tlast  = sub_ff ? 1'b1 : head_ff.row_last0;
   assign rsp_tuser  = sub_ff ? 1'b1 : head_ff.run_last0;
   assign fifo_rd    = rsp_xfer && (sub_ff || !head_ff.two);
   assign head_load  = !head_vld_ff || fifo_rd;
   assign mem_rd     = head_load && (fcnt_ff != '0);
   assign mem_wr     = fifo_wr && !(head_load && (fcnt_ff == '0));

   always_comb begin
      sub_in = sub_ff;
      if (rsp_xfer) begin
         sub_in = !sub_ff && head_ff.two;
      end
      head_vld_in = head_vld_ff;
      if (head_load) begin
         head_vld_in = (fcnt_ff != '0) || fifo_wr;
      end
      fcnt_in = fcnt_ff + cgdr_pkg::CNT_W'(mem_wr) - cgdr_pkg::CNT_W'(mem_rd);
      resv_in = resv_ff + cgdr_pkg::CNT_W'(req_xfer ? n_res : 2'd0)
                - cgdr_pkg::CNT_W'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         fifo_mem[wptr_ff] <= fifo_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (head_load) begin
         if (fcnt_ff != '0) begin
            head_ff <= fifo_mem[rptr_ff];
         end else if (fifo_wr) begin
            head_ff <= fifo_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff     <= '0;
         rptr_ff     <= '0;
         fcnt_ff     <= '0;
         head_vld_ff <= 1'b0;
         sub_ff      <= 1'b0;
         resv_ff     <= '0;
      end else begin
         if (mem_wr) begin
            wptr_ff <= wptr_ff + cgdr_pkg::FIFO_AW'(1);
         end
         if (mem_rd) begin
            rptr_ff <= rptr_ff + cgdr_pkg::FIFO_AW'(1);
         end
         fcnt_ff     <= fcnt_in;
         head_vld_ff <= head_vld_in;
         sub_ff      <= sub_in;
         resv_ff     <= resv_in;
      end
   end

   a_resv_bound: assert property (@(posedge clock) disable iff (reset)
      resv_ff <= cgdr_pkg::CNT_W'(cgdr_pkg::FIFO_DEPTH))
      else $error("results in flight exceed queue depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      mem_wr |-> (fcnt_ff < cgdr_pkg::CNT_W'(cgdr_pkg::FIFO_DEPTH)) || mem_rd)
      else $error("result queue written while full");

   a_queue_within_resv: assert property (@(posedge clock) disable iff (reset)
      (fcnt_ff + cgdr_pkg::CNT_W'(head_vld_ff)) <= resv_ff)
      else $error("queue holds more entries than reserved results");

   a_second_half: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> head_vld_ff && head_ff.two)
      else $error("second result selected for a single-result entry");

   a_ready_stops: assert property (@(posedge clock) disable iff (reset)
      (resv_ff > cgdr_pkg::CNT_W'(cgdr_pkg::FIFO_DEPTH - 2)) |-> !req_tready)
      else $error("input taken without room for its results");

endmodule
